>>> hdl/assert_macros.svh
// Assertion macros for the concurrent checks of the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// The condition must never be true.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

>>> hdl/hpa_pkg.sv
// Shared types and constants of the handle pool allocator.
package hpa_pkg;

	localparam int HANDLE_W = 6;
	localparam int STATUS_W = 2;
	localparam int CMD_W = 2;
	localparam int POOL_SIZE_DEF = 64;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TRY = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FREE = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NONE_FREE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;   // sweep one allocated-map entry to zero
		logic issue;   // capture a command word and launch the RAM reads
		logic commit;  // decide, update state and load the result register
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;  // the clearing sweep is at its last entry
	} sts_t;

endpackage

>>> hdl/hpa_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module hpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> hdl/hpa_ctrl.sv
// Controller state machine of the handle pool allocator: clearing, accept and execute.
module hpa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output hpa_pkg::ctl_t ctl,
	input  hpa_pkg::sts_t sts
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		ctl.clear = (state_q == S_CLEAR);
		ctl.issue = (state_q == S_IDLE) && in_valid;
		ctl.commit = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (sts.clear_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (ctl.commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> hdl/hpa_dp.sv
// Datapath of the handle pool allocator: free list, allocated map, counters and result register.
module hpa_dp #(
	parameter int POOL_SIZE = hpa_pkg::POOL_SIZE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [hpa_pkg::CMD_W-1:0]      in_cmd,
	input  logic [hpa_pkg::HANDLE_W-1:0]   in_handle,
	input  hpa_pkg::ctl_t                  ctl,
	output hpa_pkg::sts_t                  sts,
	output logic [hpa_pkg::HANDLE_W-1:0]   handle_out,
	output logic [hpa_pkg::STATUS_W-1:0]   status
);

	localparam int IDX_W = $clog2(POOL_SIZE);
	localparam int CNT_W = $clog2(POOL_SIZE + 1);
	localparam int HW = (IDX_W > hpa_pkg::HANDLE_W) ? IDX_W : hpa_pkg::HANDLE_W;

	// Captured command.
	logic [hpa_pkg::CMD_W-1:0] cmd_s1;
	logic [IDX_W-1:0]          hidx_s1;
	logic                      hok_s1;

	// Free-list pointers and counters.
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [CNT_W-1:0] qcount_q;
	logic [CNT_W-1:0] fresh_q;
	logic [IDX_W-1:0] clr_q;

	// Result register.
	logic [hpa_pkg::HANDLE_W-1:0] hout_q;
	logic [hpa_pkg::STATUS_W-1:0] st_q;

	logic [HW:0]      h_ext;
	logic             h_in_pool;
	logic [IDX_W-1:0] q_rd_data;
	logic [0:0]       map_rd_data;
	logic             map_we;
	logic [IDX_W-1:0] map_waddr;
	logic [0:0]       map_wdata;

	logic             is_alloc;
	logic             is_try;
	logic             is_free;
	logic             have_q;
	logic             have_fresh;
	logic             pop;
	logic             fresh_take;
	logic             free_ok;
	logic [IDX_W-1:0] grant;
	logic [HW-1:0]    grant_hw;
	logic [hpa_pkg::HANDLE_W-1:0] hout_d;
	logic [hpa_pkg::STATUS_W-1:0] st_d;

	assign h_ext = (HW + 1)'(in_handle);
	assign h_in_pool = h_ext < (HW + 1)'(POOL_SIZE);

	function automatic logic [IDX_W-1:0] next_pos(input logic [IDX_W-1:0] p);
		return (p == IDX_W'(POOL_SIZE - 1)) ? '0 : p + 1'b1;
	endfunction

	hpa_ram #(
		.WIDTH(IDX_W),
		.DEPTH(POOL_SIZE)
	) u_queue (
		.clk    (clk),
		.wr_en  (ctl.commit && free_ok),
		.wr_addr(tail_q),
		.wr_data(hidx_s1),
		.rd_en  (ctl.issue),
		.rd_addr(head_q),
		.rd_data(q_rd_data)
	);

	hpa_ram #(
		.WIDTH(1),
		.DEPTH(POOL_SIZE)
	) u_map (
		.clk    (clk),
		.wr_en  (map_we),
		.wr_addr(map_waddr),
		.wr_data(map_wdata),
		.rd_en  (ctl.issue),
		.rd_addr(h_ext[IDX_W-1:0]),
		.rd_data(map_rd_data)
	);

	always_comb begin
		is_alloc = (cmd_s1 == hpa_pkg::CMD_ALLOC);
		is_try = (cmd_s1 == hpa_pkg::CMD_TRY);
		is_free = (cmd_s1 == hpa_pkg::CMD_FREE);
		have_q = (qcount_q != '0);
		have_fresh = (fresh_q < CNT_W'(POOL_SIZE));
		pop = (is_alloc || is_try) && have_q;
		fresh_take = is_alloc && !have_q && have_fresh;
		free_ok = is_free && hok_s1 && map_rd_data[0] && (qcount_q != CNT_W'(POOL_SIZE));
		grant = have_q ? q_rd_data : fresh_q[IDX_W-1:0];
		grant_hw = HW'(grant);

		priority if (is_free) begin
			st_d = free_ok ? hpa_pkg::ST_OK : hpa_pkg::ST_INVALID;
		end else if (pop || fresh_take) begin
			st_d = hpa_pkg::ST_OK;
		end else if (is_try) begin
			st_d = hpa_pkg::ST_NONE_FREE;
		end else if (is_alloc) begin
			st_d = hpa_pkg::ST_EXHAUSTED;
		end else begin
			st_d = hpa_pkg::ST_OK;
		end
		hout_d = (pop || fresh_take) ? grant_hw[hpa_pkg::HANDLE_W-1:0] : '0;

		// The clearing sweep owns the map write port until it ends.
		map_we = ctl.clear || (ctl.commit && (pop || fresh_take || free_ok));
		map_waddr = ctl.clear ? clr_q : (is_free ? hidx_s1 : grant);
		map_wdata = (ctl.clear || is_free) ? 1'b0 : 1'b1;

		sts.clear_last = (clr_q == IDX_W'(POOL_SIZE - 1));
	end

	always_ff @(posedge clk) begin
		if (ctl.issue) begin
			cmd_s1 <= in_cmd;
			hidx_s1 <= h_ext[IDX_W-1:0];
			hok_s1 <= h_in_pool;
		end
		if (ctl.commit) begin
			hout_q <= hout_d;
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			qcount_q <= '0;
			fresh_q <= '0;
			clr_q <= '0;
		end else begin
			if (ctl.clear) begin
				clr_q <= clr_q + 1'b1;
			end
			if (ctl.commit) begin
				if (pop) begin
					head_q <= next_pos(head_q);
					qcount_q <= qcount_q - 1'b1;
				end
				if (fresh_take) begin
					fresh_q <= fresh_q + 1'b1;
				end
				if (free_ok) begin
					tail_q <= next_pos(tail_q);
					qcount_q <= qcount_q + 1'b1;
				end
			end
		end
	end

	assign handle_out = hout_q;
	assign status = st_q;

endmodule

>>> hdl/handle_pool_allocator.sv
// Top level of the handle pool allocator: stream ports, controller and datapath.
// The allocator hands out handles from a pool of POOL_SIZE entries, one command word in and
// one result word out. Allocate reuses the oldest freed handle and, when none is queued,
// issues the next never-used handle, reporting "pool exhausted" once every handle is in use.
// Try-allocate only reuses freed handles and reports "nothing free" otherwise. Deallocate
// rejects a handle that is not currently allocated with "invalid handle"; otherwise it frees
// the handle and queues it at the tail of the free list. Each command has an accept step, which
// launches the registered reads of the free-list RAM and the allocated-map RAM, and an execute
// step, which makes the decision, writes both RAMs and loads the result register once the
// output register is free or being emptied. A new command is accepted only after the last one
// has executed. The result register lets the next command word be accepted while the previous
// result still waits on the output; that command executes as soon as the result is taken.
// After reset the allocated map is swept to zero, one entry per cycle, with s_tready held low.
`include "assert_macros.svh"

module handle_pool_allocator #(
	parameter int POOL_SIZE = hpa_pkg::POOL_SIZE_DEF
) (
	input  logic       clk,
	input  logic       arst_n,

	// Command words.
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [5:0] handle, [7:6] zero
	input  logic [1:0] s_tuser,   // [1:0] cmd

	// Result words.
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [5:0] handle_out, [7:6] zero
	output logic [1:0] m_tuser    // [1:0] status
);

	hpa_pkg::ctl_t ctl;
	hpa_pkg::sts_t sts;
	logic [hpa_pkg::HANDLE_W-1:0] handle_out;

	// The controller sequences clearing, accept and execute; it also owns the output valid.
	hpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.ctl      (ctl),
		.sts      (sts)
	);

	// The datapath holds the free list, the allocated map, the counters and the result.
	hpa_dp #(
		.POOL_SIZE(POOL_SIZE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_cmd    (s_tuser),
		.in_handle (s_tdata[hpa_pkg::HANDLE_W-1:0]),
		.ctl       (ctl),
		.sts       (sts),
		.handle_out(handle_out),
		.status    (m_tuser)
	);

	assign m_tdata = {2'b00, handle_out};

	// No command word may be taken while the map is still being cleared.
	`ASSERT_NEVER(a_no_accept_in_clear, ctl.clear && s_tready, "accept ready during clear")
	// A result is only committed when the output register is free or being emptied.
	`ASSERT_SAME(a_commit_slot_free, ctl.commit, !m_tvalid || m_tready, "result overwritten")
	// A committed result is presented in the next cycle.
	`ASSERT_NEXT(a_commit_shows, ctl.commit, m_tvalid, "committed result not presented")
	// One command at a time: after an accept the block is busy executing it.
	`ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second command accepted early")

endmodule
